// File: sv/fol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fol_pkg
// shared types and constants of the frequency ordered lookup table
// ----------------------------------------------------------------------------
package fol_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned ENT_W      = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CNTF_W     = 16;
  localparam int unsigned ENTF_W     = 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wkey;
    logic [COUNT_BITS-1:0] wcnt;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  key;
    logic [CNTF_W-1:0] count;
    logic [ENTF_W-1:0] entries;
  } res_t;

endpackage

// File: sv/fol_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fol_mem
// key and count store, one write port and one registered read port
// ----------------------------------------------------------------------------
module fol_mem import fol_pkg::*; (
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [KEY_W-1:0]      rd_key_o,
  output logic [COUNT_BITS-1:0] rd_cnt_o
);

  logic [KEY_W-1:0]      key_mem [DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      key_mem[req_i.waddr] <= req_i.wkey;
      cnt_mem[req_i.waddr] <= req_i.wcnt;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_o <= key_mem[req_i.raddr];
    rd_cnt_o <= cnt_mem[req_i.raddr];
  end

endmodule

// File: sv/fol_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fol_ctrl
// sequencer: search walk, move-up walk with shift, append and read
// ----------------------------------------------------------------------------
module fol_ctrl import fol_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_op_i,
  input  logic [KEY_W-1:0]      in_key_i,
  input  logic [IDX_W-1:0]      in_idx_i,
  output mem_req_t              mem_req_o,
  input  logic [KEY_W-1:0]      rd_key_i,
  input  logic [COUNT_BITS-1:0] rd_cnt_i,
  output logic                  done_o,
  output res_t                  res_o,
  input  logic                  take_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_RDW   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_PLACE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [ENT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [1:0]            op_q;
  logic [KEY_W-1:0]      key_q;
  logic [IDX_W-1:0]      idx_q;
  logic [COUNT_BITS-1:0] c_q, c_d;
  res_t                  res_q, res_d;
  logic                  accept;
  logic                  hit;
  logic [COUNT_BITS-1:0] inc_cnt;

  assign accept  = in_valid_i && in_ready_o;
  assign hit     = (rd_key_i == key_q);
  assign inc_cnt = (&rd_cnt_i) ? rd_cnt_i : rd_cnt_i + 1'b1;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    c_d        = c_q;
    res_d      = res_q;
    mem_req_o  = '0;
    mem_req_o.raddr = ptr_q;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = S_CMD;
      end
      S_CMD: begin
        res_d = '0;
        if (op_q == OP_APPEND) begin
          res_d.key = key_q;
          if (cnt_q >= ENT_W'(DEPTH)) begin
            res_d.status = ST_FULL;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = cnt_q[IDX_W-1:0];
            mem_req_o.wkey  = key_q;
            mem_req_o.wcnt  = '0;
            res_d.status    = ST_OK;
            res_d.position  = POS_W'(cnt_q);
            cnt_d           = cnt_q + 1'b1;
          end
          state_d = S_DONE;
        end else if (op_q[1]) begin
          if ({1'b0, idx_q} >= cnt_q) begin
            res_d.status   = ST_RANGE;
            res_d.position = POS_W'(idx_q);
            state_d        = S_DONE;
          end else begin
            mem_req_o.raddr = idx_q;
            state_d         = S_RDW;
          end
        end else begin
          res_d.key = key_q;
          if (cnt_q == '0) begin
            res_d.status = ST_MISSING;
            state_d      = S_DONE;
          end else begin
            ptr_d           = '0;
            mem_req_o.raddr = '0;
            state_d         = S_SRCH;
          end
        end
      end
      S_RDW: begin
        res_d.status   = ST_OK;
        res_d.position = POS_W'(idx_q);
        res_d.key      = rd_key_i;
        res_d.count    = CNTF_W'(rd_cnt_i);
        state_d        = S_DONE;
      end
      S_SRCH: begin
        if (hit) begin
          c_d = inc_cnt;
          if (ptr_q == '0) begin
            state_d = S_PLACE;
          end else begin
            mem_req_o.raddr = ptr_q - 1'b1;
            state_d         = S_MOVE;
          end
        end else if (({1'b0, ptr_q} + 1'b1) >= cnt_q) begin
          res_d.status = ST_MISSING;
          state_d      = S_DONE;
        end else begin
          ptr_d           = ptr_q + 1'b1;
          mem_req_o.raddr = ptr_q + 1'b1;
        end
      end
      S_MOVE: begin
        // read data holds the entry just ahead of ptr
        if (rd_cnt_i <= c_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ptr_q;
          mem_req_o.wkey  = rd_key_i;
          mem_req_o.wcnt  = rd_cnt_i;
          ptr_d           = ptr_q - 1'b1;
          mem_req_o.raddr = ptr_q - IDX_W'(2);
          if (ptr_q == IDX_W'(1)) state_d = S_PLACE;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q;
        mem_req_o.wkey  = key_q;
        mem_req_o.wcnt  = c_q;
        res_d.status    = ST_OK;
        res_d.position  = POS_W'(ptr_q);
        res_d.key       = key_q;
        res_d.count     = CNTF_W'(c_q);
        state_d         = S_DONE;
      end
      S_DONE: begin
        done_o = 1'b1;
        if (take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o         = res_q;
    res_o.entries = ENTF_W'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    c_q   <= c_d;
    res_q <= res_d;
    if (accept) begin
      op_q  <= in_op_i;
      key_q <= in_key_i;
      idx_q <= in_idx_i;
    end
  end

endmodule

// File: sv/frequency_ordered_list_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_ordered_list_lookup_top
// frequency count self-organising lookup table with a stream interface
//
//   channel   dir  bits  contents
//   s_axis    in   40    op, key, index
//   m_axis    out  64    status, position, key_out, count_out, entries
//
// one item at a time; an append writes the key at the end, a read returns the
// entry at the index or a range status beyond the entries, and a locate walks
// from the top, gives a missing status on no hit, and on a hit moves the key
// up past entries of no higher count; reset clears the entry count, the store
// is not cleared; a finished result waits in the output register and the next
// item is accepted while it waits, a second result stalls until the first is taken
// ----------------------------------------------------------------------------
module frequency_ordered_list_lookup_top import fol_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // op[1:0], key[33:2], index[37:34]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // status, position, key_out, count_out, entries
);

  mem_req_t              mem_req;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  res_done;
  logic                  res_take;
  res_t                  res;
  res_t                  out_q;
  logic                  out_vld_q;

  assign res_take = res_done && (!out_vld_q || m_axis_tready_i);

  fol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tdata_i[1:0]),
    .in_key_i   (s_axis_tdata_i[33:2]),
    .in_idx_i   (s_axis_tdata_i[34 +: IDX_W]),
    .mem_req_o  (mem_req),
    .rd_key_i   (rd_key),
    .rd_cnt_i   (rd_cnt),
    .done_o     (res_done),
    .res_o      (res),
    .take_i     (res_take)
  );

  fol_mem u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_key_o (rd_key),
    .rd_cnt_o (rd_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_take) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= res;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_q.entries, out_q.count, out_q.key,
                            out_q.position, out_q.status};

  a_accept_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !res_done)
    else $error("item accepted while a result is pending");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> m_axis_tvalid_o)
    else $error("result taken but output not valid");

  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.entries <= ENTF_W'(DEPTH)))
    else $error("entry count beyond depth");

  a_pos_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.status == ST_OK) |->
      ({1'b0, out_q.position} < out_q.entries))
    else $error("position outside held entries");

endmodule
